>>> rtl/mmp_pkg.sv
// Shared constants and helpers for the modular matrix power block.
package mmp_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int VAL_W   = 62;
    localparam int EXP_W   = 64;
    localparam int DIM_W   = 4;
    localparam int REG_IDX_W = 2;
    localparam int CNT_W   = 6;

    localparam logic [REG_IDX_W-1:0] REG_DIMENSION = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODULUS   = 2'd1;

    localparam logic [DIM_W-1:0] DIM_CAP   = DIM_W'(MAX_DIM < 8 ? MAX_DIM : 8);
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd1;
    localparam logic [VAL_W-1:0] MOD_RESET = 62'd1000000007;

    localparam logic [0:0] ACT_LOAD  = 1'b0;
    localparam logic [0:0] ACT_START = 1'b1;

    // x, y < m: one add and one conditional subtract
    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] x,
                                                  input logic [VAL_W-1:0] y,
                                                  input logic [VAL_W-1:0] m);
        logic [VAL_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[VAL_W-1:0];
    endfunction

    // one restoring step of a bit-serial remainder, rem < m
    function automatic logic [VAL_W-1:0] rem_step(input logic [VAL_W-1:0] rem,
                                                   input logic            bit_in,
                                                   input logic [VAL_W-1:0] m);
        logic [VAL_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[VAL_W-1:0];
    endfunction

endpackage

>>> rtl/mmp_cmd_if.sv
// Command channel: element loads and start beats.
interface mmp_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [mmp_pkg::IDX_W-1:0]       row;
    logic [mmp_pkg::IDX_W-1:0]       col;
    logic [mmp_pkg::VAL_W-1:0]       value;
    logic [mmp_pkg::EXP_W-1:0]       exponent;

    modport source (output valid, action, row, col, value, exponent, input ready);
    modport sink   (input valid, action, row, col, value, exponent, output ready);
endinterface

>>> rtl/mmp_res_if.sv
// Result channel: one matrix element per beat.
interface mmp_res_if;
    logic                            valid;
    logic                            ready;
    logic [mmp_pkg::IDX_W-1:0]       row_res;
    logic [mmp_pkg::IDX_W-1:0]       col_res;
    logic [mmp_pkg::VAL_W-1:0]       value_res;
    logic                            last;

    modport source (output valid, row_res, col_res, value_res, last, input ready);
    modport sink   (input valid, row_res, col_res, value_res, last, output ready);
endinterface

>>> rtl/modular_matrix_power_top.sv
// Matrix power modulo m by square-and-multiply with bit-serial modular arithmetic.
//
//  port      | dir | beat contents
//  ----------+-----+---------------------------------------------
//  cmd       | in  | action, row, col, value, exponent
//  res       | out | row_res, col_res, value_res, last
//  wr_*      | in  | register index, data (dimension, modulus)
//
// A load beat reduces the value one bit per cycle.
// A start beat first fills the accumulator and power stores, then runs each matrix
// product with one bit-serial multiply per term, up to 2 products per exponent
// bit; then the result is sent one element per beat.
// Reset clears the control registers and the base valid bits; no clearing pass.
// cmd is taken only while idle; a stalled res beat holds the sequencer.
module modular_matrix_power_top (
    input  logic                               clk,
    input  logic                               rst_n,
    mmp_cmd_if.sink                            cmd,
    mmp_res_if.source                          res,
    input  logic                               wr_en,
    input  logic [mmp_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [mmp_pkg::VAL_W-1:0]          wr_data
);
    import mmp_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_LOAD_RED = 15'b000000000000010,
        S_INIT_RD  = 15'b000000000000100,
        S_INIT_LD  = 15'b000000000001000,
        S_INIT_RED = 15'b000000000010000,
        S_LOOP     = 15'b000000000100000,
        S_MM_RD    = 15'b000000001000000,
        S_MM_LD    = 15'b000000010000000,
        S_MM_MUL   = 15'b000000100000000,
        S_MM_ACC   = 15'b000001000000000,
        S_COPY_RD  = 15'b000010000000000,
        S_COPY_WR  = 15'b000100000000000,
        S_OUT_RD   = 15'b001000000000000,
        S_OUT_LD   = 15'b010000000000000,
        S_OUT_WAIT = 15'b100000000000000
    } state_t;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VAL_W - 1);

    state_t              state_reg, state_next;
    logic [DIM_W-1:0]    dim_reg;
    logic [VAL_W-1:0]    mod_reg;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic [IDX_W-1:0]    i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [ADDR_W-1:0]   la_reg, la_next;
    logic                sq_reg, sq_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VAL_W-1:0]    src_reg, src_next, rem_reg, rem_next;
    logic [VAL_W-1:0]    a_reg, a_next, b_reg, b_next, r_reg, r_next;
    logic [VAL_W-1:0]    sum_reg, sum_next;
    logic                res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]    res_row_reg, res_row_next, res_col_reg, res_col_next;
    logic [VAL_W-1:0]    res_val_reg, res_val_next;
    logic                res_last_reg, res_last_next;

    logic [VAL_W-1:0]    base_mem [CELLS];
    logic [VAL_W-1:0]    acc_mem  [CELLS];
    logic [VAL_W-1:0]    prod_mem [CELLS];
    logic [VAL_W-1:0]    scr_mem  [CELLS];
    logic [CELLS-1:0]    base_vld_reg;
    logic [VAL_W-1:0]    base_q_reg, acc_q_reg, pa_q_reg, pb_q_reg, sc_q_reg;
    logic                base_vq_reg;

    logic [VAL_W-1:0]    m_eff, one_m, red_step, sum_new, x_q;
    logic [DIM_W-1:0]    d_eff;
    logic [IDX_W-1:0]    dm1;
    logic                cell_last, red_done;
    logic [ADDR_W-1:0]   acc_raddr;
    logic                base_we, acc_we, prod_we, scr_we;
    logic [VAL_W-1:0]    acc_wd, prod_wd;

    always_comb
    begin
        m_eff = (mod_reg == '0) ? VAL_W'(1) : mod_reg;
        one_m = (m_eff == VAL_W'(1)) ? '0 : VAL_W'(1);
        if (dim_reg == '0)
            d_eff = DIM_W'(1);
        else if (dim_reg > DIM_CAP)
            d_eff = DIM_CAP;
        else
            d_eff = dim_reg;
    end

    assign dm1       = IDX_W'(d_eff - DIM_W'(1));
    assign cell_last = (i_reg == dm1) && (j_reg == dm1);
    assign red_step  = rem_step(rem_reg, src_reg[VAL_W-1], m_eff);
    assign red_done  = (cnt_reg == LAST_BIT);
    assign sum_new   = add_mod(sum_reg, r_reg, m_eff);
    assign x_q       = sq_reg ? pa_q_reg : acc_q_reg;
    assign acc_raddr = (state_reg == S_OUT_RD) ? {i_reg, j_reg} : {i_reg, k_reg};

    assign cmd.ready     = (state_reg == S_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.row_res   = res_row_reg;
    assign res.col_res   = res_col_reg;
    assign res.value_res = res_val_reg;
    assign res.last      = res_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
            mod_reg <= MOD_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DIMENSION: dim_reg <= wr_data[DIM_W-1:0];
                REG_MODULUS:   mod_reg <= wr_data;
                default:       ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        la_next        = la_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        src_next       = src_reg;
        rem_next       = rem_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        res_valid_next = res_valid_reg;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_val_next   = res_val_reg;
        res_last_next  = res_last_reg;
        base_we        = 1'b0;
        acc_we         = 1'b0;
        prod_we        = 1'b0;
        scr_we         = 1'b0;
        acc_wd         = sc_q_reg;
        prod_wd        = sc_q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == ACT_LOAD)
                    begin
                        la_next    = {cmd.row, cmd.col};
                        src_next   = cmd.value;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_LOAD_RED;
                    end
                    else
                    begin
                        exp_next   = cmd.exponent;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_INIT_RD;
                    end
                end
            end

            S_LOAD_RED:
            begin
                rem_next = red_step;
                src_next = src_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (red_done)
                begin
                    base_we    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_INIT_RD:
                state_next = S_INIT_LD;

            S_INIT_LD:
            begin
                src_next   = base_vq_reg ? base_q_reg : '0;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_INIT_RED;
            end

            S_INIT_RED:
            begin
                rem_next = red_step;
                src_next = src_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (red_done)
                begin
                    prod_we = 1'b1;
                    prod_wd = red_step;
                    acc_we  = 1'b1;
                    acc_wd  = (i_reg == j_reg) ? one_m : '0;
                    if (cell_last)
                    begin
                        state_next = S_LOOP;
                    end
                    else
                    begin
                        if (j_reg == dm1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                            j_next = j_reg + IDX_W'(1);
                        state_next = S_INIT_RD;
                    end
                end
            end

            S_LOOP:
            begin
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
                sum_next = '0;
                if (exp_reg == '0)
                    state_next = S_OUT_RD;
                else if (exp_reg[0])
                begin
                    // multiply into the accumulator, then drop the bit
                    exp_next   = {exp_reg[EXP_W-1:1], 1'b0};
                    sq_next    = 1'b0;
                    state_next = S_MM_RD;
                end
                else
                begin
                    exp_next = exp_reg >> 1;
                    sq_next  = 1'b1;
                    if (exp_reg[EXP_W-1:1] == '0)
                        state_next = S_OUT_RD;
                    else
                        state_next = S_MM_RD;
                end
            end

            S_MM_RD:
                state_next = S_MM_LD;

            S_MM_LD:
            begin
                a_next     = x_q;
                b_next     = pb_q_reg;
                r_next     = '0;
                cnt_next   = '0;
                state_next = S_MM_MUL;
            end

            S_MM_MUL:
            begin
                if (b_reg[0])
                    r_next = add_mod(r_reg, a_reg, m_eff);
                a_next   = add_mod(a_reg, a_reg, m_eff);
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (red_done)
                    state_next = S_MM_ACC;
            end

            S_MM_ACC:
            begin
                if (k_reg == dm1)
                begin
                    scr_we   = 1'b1;
                    sum_next = '0;
                    k_next   = '0;
                    if (cell_last)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_COPY_RD;
                    end
                    else
                    begin
                        if (j_reg == dm1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                            j_next = j_reg + IDX_W'(1);
                        state_next = S_MM_RD;
                    end
                end
                else
                begin
                    sum_next   = sum_new;
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_MM_RD;
                end
            end

            S_COPY_RD:
                state_next = S_COPY_WR;

            S_COPY_WR:
            begin
                acc_we  = !sq_reg;
                prod_we = sq_reg;
                if (cell_last)
                    state_next = S_LOOP;
                else
                begin
                    if (j_reg == dm1)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                    end
                    else
                        j_next = j_reg + IDX_W'(1);
                    state_next = S_COPY_RD;
                end
            end

            S_OUT_RD:
                state_next = S_OUT_LD;

            S_OUT_LD:
            begin
                res_valid_next = 1'b1;
                res_row_next   = i_reg;
                res_col_next   = j_reg;
                res_val_next   = acc_q_reg;
                res_last_next  = cell_last;
                state_next     = S_OUT_WAIT;
            end

            S_OUT_WAIT:
            begin
                if (res.ready)
                begin
                    res_valid_next = 1'b0;
                    if (cell_last)
                        state_next = S_IDLE;
                    else
                    begin
                        if (j_reg == dm1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                            j_next = j_reg + IDX_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            sq_reg        <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            base_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            sq_reg        <= sq_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (base_we)
                base_vld_reg[la_reg] <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        la_reg      <= la_next;
        src_reg     <= src_next;
        rem_reg     <= rem_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        sum_reg     <= sum_next;
        res_row_reg <= res_row_next;
        res_col_reg <= res_col_next;
        res_val_reg <= res_val_next;
        res_last_reg <= res_last_next;
    end

    // element stores
    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[la_reg] <= red_step;
        base_q_reg  <= base_mem[{i_reg, j_reg}];
        base_vq_reg <= base_vld_reg[{i_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[{i_reg, j_reg}] <= acc_wd;
        acc_q_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prod_we)
            prod_mem[{i_reg, j_reg}] <= prod_wd;
        pa_q_reg <= prod_mem[{i_reg, k_reg}];
        pb_q_reg <= prod_mem[{k_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[{i_reg, j_reg}] <= sum_new;
        sc_q_reg <= scr_mem[{i_reg, j_reg}];
    end

    a_res_only_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (state_reg == S_OUT_WAIT))
        else $error("result beat outside output phase");

    a_idle_exp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (exp_reg == '0))
        else $error("exponent left over at idle");

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOAD_RED) || (state_reg == S_INIT_RED)) |-> (rem_reg < m_eff))
        else $error("serial remainder not reduced");

    a_mul_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MM_ACC) |-> (r_reg < m_eff) && (sum_reg < m_eff))
        else $error("product term not reduced");

endmodule

>>> sim/mmp_checker.sv
// Scoreboard for the modular matrix power block: predicts result matrices and compares beats.
module mmp_checker
    import mmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mmp_cmd_if                   cmd,
    mmp_res_if                   res,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [VAL_W-1:0]     wr_data,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [IDX_W-1:0] row_res;
        logic [IDX_W-1:0] col_res;
        logic [VAL_W-1:0] value_res;
        logic             last;
    } elem_t;

    typedef logic [VAL_W-1:0] mat_t [CELLS];

    logic [DIM_W-1:0] dim_q;
    logic [VAL_W-1:0] mod_q;
    mat_t             base_mat;
    elem_t            elem_q[$];

    function automatic logic [VAL_W-1:0] mul_m(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b,
                                               input logic [VAL_W-1:0] m);
        logic [2*VAL_W-1:0] p;
        p = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
        return VAL_W'(p % {{VAL_W{1'b0}}, m});
    endfunction

    function automatic mat_t mat_prod(input mat_t x, input mat_t y, input int d,
                                      input logic [VAL_W-1:0] m);
        mat_t         z;
        logic [VAL_W:0] s;
        z = x;
        for (int i = 0; i < d; i++)
        begin
            for (int j = 0; j < d; j++)
            begin
                s = '0;
                for (int k = 0; k < d; k++)
                begin
                    s = s + mul_m(x[i*MAX_DIM+k], y[k*MAX_DIM+j], m);
                    if (s >= {1'b0, m})
                    begin
                        s = s - {1'b0, m};
                    end
                end
                z[i*MAX_DIM+j] = s[VAL_W-1:0];
            end
        end
        return z;
    endfunction

    task automatic predict_power(input logic [EXP_W-1:0] e);
        mat_t             acc;
        mat_t             pw;
        int               d;
        logic [VAL_W-1:0] m;
        elem_t            el;
        m = (mod_q == '0) ? VAL_W'(1) : mod_q;
        d = (dim_q == '0) ? 1 : ((dim_q > DIM_CAP) ? int'(DIM_CAP) : int'(dim_q));
        for (int i = 0; i < CELLS; i++)
        begin
            acc[i] = '0;
            pw[i]  = base_mat[i] % m;
        end
        for (int i = 0; i < d; i++)
        begin
            acc[i*MAX_DIM+i] = VAL_W'(1) % m;
        end
        while (e != '0)
        begin
            if (e[0])
            begin
                acc = mat_prod(acc, pw, d, m);
            end
            e = e >> 1;
            if (e != '0)
            begin
                pw = mat_prod(pw, pw, d, m);
            end
        end
        for (int i = 0; i < d; i++)
        begin
            for (int j = 0; j < d; j++)
            begin
                el.row_res   = IDX_W'(i);
                el.col_res   = IDX_W'(j);
                el.value_res = acc[i*MAX_DIM+j];
                el.last      = (i == d - 1) && (j == d - 1);
                elem_q.push_back(el);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_q   <= DIM_RESET;
            mod_q   <= MOD_RESET;
            errors  <= 0;
            pending <= 0;
            for (int i = 0; i < CELLS; i++)
            begin
                base_mat[i] = '0;
            end
            elem_q.delete();
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_DIMENSION)
                begin
                    dim_q <= wr_data[DIM_W-1:0];
                end
                else if (wr_index == REG_MODULUS)
                begin
                    mod_q <= wr_data;
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.action == ACT_LOAD)
                begin
                    base_mat[{cmd.row, cmd.col}] =
                        cmd.value % ((mod_q == '0) ? VAL_W'(1) : mod_q);
                end
                else
                begin
                    predict_power(cmd.exponent);
                end
            end
            if (res.valid && res.ready)
            begin
                if (elem_q.size() == 0)
                begin
                    $display("%0t: unexpected beat row %0d col %0d value %0d last %0b",
                             $time, res.row_res, res.col_res, res.value_res, res.last);
                    errors <= errors + 1;
                end
                else
                begin
                    elem_t e;
                    e = elem_q.pop_front();
                    if (e.row_res !== res.row_res || e.col_res !== res.col_res ||
                        e.value_res !== res.value_res || e.last !== res.last)
                    begin
                        $display("%0t: mismatch expected r%0d c%0d v%0d l%0b got r%0d c%0d v%0d l%0b",
                                 $time, e.row_res, e.col_res, e.value_res, e.last,
                                 res.row_res, res.col_res, res.value_res, res.last);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= elem_q.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// Stimulus and verdict for the modular matrix power block.
module tb_top;
    import mmp_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [VAL_W-1:0]     wr_data;
    int                   errors;
    int                   pending;
    bit                   quiet;

    mmp_cmd_if cmd ();
    mmp_res_if res ();

    modular_matrix_power_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .res      (res),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    mmp_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .res      (res),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure in bursts
    initial
    begin
        int n;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                res.ready <= 1'b1;
            end
            else
            begin
                res.ready <= $urandom_range(0, 2) != 0;
                n = $urandom_range(1, 18);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic send(input logic act, input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                        input logic [VAL_W-1:0] v, input logic [EXP_W-1:0] e);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        @(negedge clk);
        cmd.valid    <= 1'b1;
        cmd.action   <= act;
        cmd.row      <= r;
        cmd.col      <= c;
        cmd.value    <= v;
        cmd.exponent <= e;
        do
        begin
            @(posedge clk);
        end
        while (!cmd.ready);
    endtask

    task automatic load(input int r, input int c, input logic [VAL_W-1:0] v);
        send(ACT_LOAD, IDX_W'(r), IDX_W'(c), v, {$urandom, $urandom});
    endtask

    task automatic start(input logic [EXP_W-1:0] e);
        send(ACT_START, IDX_W'($urandom), IDX_W'($urandom), VAL_W'({$urandom, $urandom}), e);
    endtask

    task automatic drain();
        @(negedge clk);
        cmd.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        // a trailing load may still be reducing its value
        repeat (100) @(negedge clk);
    endtask

    // only called when the block is idle
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VAL_W-1:0] d);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= d;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] rand_val();
        return VAL_W'({$urandom, $urandom});
    endfunction

    function automatic logic [VAL_W-1:0] rand_mod();
        case ($urandom_range(0, 4))
            0:       return VAL_W'($urandom_range(2, 1000));
            1:       return '1;
            2:       return VAL_W'($urandom);
            default: return rand_val();
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] rand_exp(input int d);
        logic [EXP_W-1:0] e;
        e = {$urandom, $urandom};
        if (d <= 2)
        begin
            return e;
        end
        else if (d <= 4)
        begin
            return EXP_W'(e[9:0]);
        end
        return EXP_W'(e[3:0]);
    endfunction

    initial
    begin
        int d;
        int n;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        wr_en     = 1'b0;
        wr_index  = '0;
        wr_data   = '0;
        cmd.valid    = 1'b0;
        cmd.action   = ACT_LOAD;
        cmd.row      = '0;
        cmd.col      = '0;
        cmd.value    = '0;
        cmd.exponent = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, d = 1
        start(64'd5);
        load(0, 0, '1);
        start('0);
        start(64'd1);
        start('1);
        load(7, 7, '1);
        drain();

        write_reg(REG_DIMENSION, VAL_W'(2));
        write_reg(REG_MODULUS, '1);
        load(0, 0, '1);
        load(0, 1, VAL_W'(62'h2AAA_AAAA_AAAA_AAAA));
        load(1, 0, VAL_W'(62'h1555_5555_5555_5555));
        load(1, 1, '1 - 1);
        start(64'd5);
        start('1);
        drain();

        // reduced again under a smaller modulus
        write_reg(REG_MODULUS, VAL_W'(1000));
        start(64'd3);
        drain();
        write_reg(REG_MODULUS, '0);
        start(64'd7);
        drain();
        write_reg(REG_MODULUS, VAL_W'(1));
        start('0);
        drain();
        write_reg(REG_DIMENSION, '0);
        write_reg(REG_MODULUS, VAL_W'(97));
        start(64'd9);
        drain();
        // saturates to the full store
        write_reg(REG_DIMENSION, VAL_W'(15));
        start(64'd2);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 6)
            begin
                quiet = 1'b1;
            end
            case ($urandom_range(0, 9))
                0:       d = 8;
                1:       d = $urandom_range(5, 7);
                2, 3:    d = $urandom_range(3, 4);
                default: d = $urandom_range(1, 2);
            endcase
            if (ph == 3)
            begin
                d = 8;
            end
            write_reg(REG_DIMENSION, VAL_W'(d == 8 && $urandom_range(0, 1) ? 9 : d));
            write_reg(REG_MODULUS, rand_mod());
            n = $urandom_range(6, 12);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    load($urandom_range(0, 7), $urandom_range(0, 7), rand_val());
                end
                else
                begin
                    load($urandom_range(0, d - 1), $urandom_range(0, d - 1), rand_val());
                end
            end
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
            begin
                start(rand_exp(d));
                if (d <= 2 && $urandom_range(0, 1))
                begin
                    load($urandom_range(0, 1), $urandom_range(0, 1), rand_val());
                end
            end
            drain();
        end

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/mmp_pkg.sv
rtl/mmp_cmd_if.sv
rtl/mmp_res_if.sv
rtl/modular_matrix_power_top.sv
sim/mmp_checker.sv
sim/tb_top.sv
